// File: rtl/skd_pkg.sv
// ----------------------------------------------------------------------------
// Scancode keyboard decoder package
// Shared constants, command and status types, and the set-1 to ASCII tables.
// ----------------------------------------------------------------------------
package skd_pkg;

  localparam int FIFO_DEPTH_DEF = 256;
  localparam int CODE_W         = 7;
  localparam int CHAR_W         = 7;
  localparam int BYTE_W         = 8;

  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [CODE_W-1:0] SC_LSHIFT = 7'h2A;
  localparam logic [CODE_W-1:0] SC_RSHIFT = 7'h36;
  localparam logic [CODE_W-1:0] SC_CTRL   = 7'h1D;
  localparam logic [CODE_W-1:0] SC_ALT    = 7'h38;
  localparam logic [CODE_W-1:0] SC_CAPS   = 7'h3A;

  typedef struct packed {
    logic do_scan;
    logic do_empty_read;
    logic do_pop;
    logic do_xlate;
  } skd_cmd_t;

  typedef struct packed {
    logic empty;
  } skd_stat_t;

  function automatic logic [CHAR_W-1:0] plain_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5B;
      7'd27: c = 7'h5D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;
      7'd40: c = 7'h27;
      7'd41: c = 7'h60;
      7'd43: c = 7'h5C;
      7'd44: c = 7'h7A;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;
      7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] shift_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] c;
    case (code)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h21;
      7'd3:  c = 7'h40;
      7'd4:  c = 7'h23;
      7'd5:  c = 7'h24;
      7'd6:  c = 7'h25;
      7'd7:  c = 7'h5E;
      7'd8:  c = 7'h26;
      7'd9:  c = 7'h2A;
      7'd10: c = 7'h28;
      7'd11: c = 7'h29;
      7'd12: c = 7'h5F;
      7'd13: c = 7'h2B;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h51;
      7'd17: c = 7'h57;
      7'd18: c = 7'h45;
      7'd19: c = 7'h52;
      7'd20: c = 7'h54;
      7'd21: c = 7'h59;
      7'd22: c = 7'h55;
      7'd23: c = 7'h49;
      7'd24: c = 7'h4F;
      7'd25: c = 7'h50;
      7'd26: c = 7'h7B;
      7'd27: c = 7'h7D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h41;
      7'd31: c = 7'h53;
      7'd32: c = 7'h44;
      7'd33: c = 7'h46;
      7'd34: c = 7'h47;
      7'd35: c = 7'h48;
      7'd36: c = 7'h4A;
      7'd37: c = 7'h4B;
      7'd38: c = 7'h4C;
      7'd39: c = 7'h3A;
      7'd40: c = 7'h22;
      7'd41: c = 7'h7E;
      7'd43: c = 7'h7C;
      7'd44: c = 7'h5A;
      7'd45: c = 7'h58;
      7'd46: c = 7'h43;
      7'd47: c = 7'h56;
      7'd48: c = 7'h42;
      7'd49: c = 7'h4E;
      7'd50: c = 7'h4D;
      7'd51: c = 7'h3C;
      7'd52: c = 7'h3E;
      7'd53: c = 7'h3F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Letters follow shift XOR caps; every other key follows shift alone.
  function automatic logic [CHAR_W-1:0] xlate(input logic [CODE_W-1:0] code,
                                               input logic shift,
                                               input logic caps);
    logic [CHAR_W-1:0] base;
    logic              upper;
    base  = plain_char(code);
    upper = (base inside {[7'h61:7'h7A]}) ? (shift ^ caps) : shift;
    return upper ? shift_char(code) : base;
  endfunction

endpackage

// File: rtl/skd_ctrl.sv
// ----------------------------------------------------------------------------
// Scancode keyboard decoder controller
// Sequences one word at a time: accept, optional buffer fetch, deliver.
// ----------------------------------------------------------------------------
module skd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  output logic                out_valid,
  input  logic                out_ready,
  input  skd_pkg::skd_stat_t  stat,
  output skd_pkg::skd_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_SEND  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SEND);
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.do_scan       = accept && (req_type == skd_pkg::REQ_SCAN);
    cmd.do_empty_read = accept && (req_type == skd_pkg::REQ_READ) && stat.empty;
    cmd.do_pop        = accept && (req_type == skd_pkg::REQ_READ) && !stat.empty;
    cmd.do_xlate      = (state == S_FETCH);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.do_pop) begin
          state_next = S_FETCH;
        end else if (accept) begin
          state_next = S_SEND;
        end
      end
      S_FETCH: begin
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/skd_dp.sv
// ----------------------------------------------------------------------------
// Scancode keyboard decoder datapath
// Modifier flags, the key ring buffer, translation and the result register.
// ----------------------------------------------------------------------------
module skd_dp #(
  parameter int FIFO_DEPTH = skd_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  skd_pkg::skd_cmd_t              cmd,
  output skd_pkg::skd_stat_t             stat,
  input  logic [skd_pkg::BYTE_W-1:0]     scan_byte,
  output logic                           key_valid,
  output logic [skd_pkg::CHAR_W-1:0]     char_code,
  output logic [skd_pkg::CODE_W-1:0]     key_code,
  output logic                           dropped,
  output logic                           shift_down,
  output logic                           ctrl_down,
  output logic                           alt_down,
  output logic                           caps_on
);

  localparam int IDX_W = $clog2(FIFO_DEPTH);

  logic [skd_pkg::CODE_W-1:0] key_store [FIFO_DEPTH];
  logic [skd_pkg::CODE_W-1:0] rd_data;
  logic [IDX_W-1:0]           head_index;
  logic [IDX_W-1:0]           tail_index;
  logic [IDX_W-1:0]           head_inc;
  logic [IDX_W-1:0]           tail_inc;
  logic                       shift_flag;
  logic                       ctrl_flag;
  logic                       alt_flag;
  logic                       caps_flag;
  logic [skd_pkg::CODE_W-1:0] code;
  logic                       rel;
  logic                       is_shift;
  logic                       is_ctrl;
  logic                       is_alt;
  logic                       is_caps;
  logic                       is_key;
  logic                       full;
  logic                       push;

  assign head_inc = (head_index == IDX_W'(FIFO_DEPTH - 1)) ? '0 : head_index + 1'b1;
  assign tail_inc = (tail_index == IDX_W'(FIFO_DEPTH - 1)) ? '0 : tail_index + 1'b1;

  assign code     = scan_byte[skd_pkg::CODE_W-1:0];
  assign rel      = scan_byte[skd_pkg::BYTE_W-1];
  assign is_shift = (code == skd_pkg::SC_LSHIFT) || (code == skd_pkg::SC_RSHIFT);
  assign is_ctrl  = (code == skd_pkg::SC_CTRL);
  assign is_alt   = (code == skd_pkg::SC_ALT);
  assign is_caps  = (code == skd_pkg::SC_CAPS);
  assign is_key   = !rel && !is_shift && !is_ctrl && !is_alt && !is_caps;
  assign full     = (tail_inc == head_index);
  assign push     = cmd.do_scan && is_key && !full;

  assign stat.empty = (head_index == tail_index);

  always_ff @(posedge clk) begin
    if (push) begin
      key_store[tail_index] <= code;
    end
    if (cmd.do_pop) begin
      rd_data <= key_store[head_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      tail_index <= '0;
      shift_flag <= 1'b0;
      ctrl_flag  <= 1'b0;
      alt_flag   <= 1'b0;
      caps_flag  <= 1'b0;
    end else begin
      if (push) begin
        tail_index <= tail_inc;
      end
      if (cmd.do_pop) begin
        head_index <= head_inc;
      end
      if (cmd.do_scan) begin
        if (is_shift) begin
          shift_flag <= !rel;
        end
        if (is_ctrl) begin
          ctrl_flag <= !rel;
        end
        if (is_alt) begin
          alt_flag <= !rel;
        end
        if (is_caps && !rel) begin
          caps_flag <= !caps_flag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_scan || cmd.do_empty_read) begin
      key_valid <= 1'b0;
      char_code <= '0;
      key_code  <= '0;
      dropped   <= cmd.do_scan && is_key && full;
    end else if (cmd.do_xlate) begin
      key_valid <= 1'b1;
      char_code <= skd_pkg::xlate(rd_data, shift_flag, caps_flag);
      key_code  <= rd_data;
      dropped   <= 1'b0;
    end
  end

  assign shift_down = shift_flag;
  assign ctrl_down  = ctrl_flag;
  assign alt_down   = alt_flag;
  assign caps_on    = caps_flag;

endmodule

// File: rtl/scancode_keyboard_decoder_fifo.sv
// ----------------------------------------------------------------------------
// Set-1 scancode keyboard decoder with key buffer
// Input words carry either a scancode byte (req_type 0) or a read request
// (req_type 1); every input word yields exactly one output word.
//
// Scancode words update the shift, ctrl, alt and caps flags or push the make
// code into a ring buffer that holds FIFO_DEPTH-1 codes; when it is full the
// code is lost and dropped is set. Read words pop the oldest code and return
// it with its ASCII translation, or key_valid low when the buffer is empty.
// The modifier outputs show the flags after the word was applied.
//
// A scancode word or an empty read has its result registered in the cycle
// after acceptance; a read of a buffered key passes first through the
// registered buffer memory read and then through the registered
// translation. One word is worked on at a time, so no new word is accepted
// until the receiver has taken the result of the last one.
// Reset clears the flags and empties the buffer. While out_valid is high and
// out_ready is low the result holds and in_ready stays low.
// ----------------------------------------------------------------------------
module scancode_keyboard_decoder_fifo #(
  parameter int FIFO_DEPTH = skd_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           req_type,
  input  logic [skd_pkg::BYTE_W-1:0]     scan_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           key_valid,
  output logic [skd_pkg::CHAR_W-1:0]     char_code,
  output logic [skd_pkg::CODE_W-1:0]     key_code,
  output logic                           dropped,
  output logic                           shift_down,
  output logic                           ctrl_down,
  output logic                           alt_down,
  output logic                           caps_on
);

  skd_pkg::skd_cmd_t  cmd;
  skd_pkg::skd_stat_t stat;

  skd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skd_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .scan_byte  (scan_byte),
    .key_valid  (key_valid),
    .char_code  (char_code),
    .key_code   (key_code),
    .dropped    (dropped),
    .shift_down (shift_down),
    .ctrl_down  (ctrl_down),
    .alt_down   (alt_down),
    .caps_on    (caps_on)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode keyboard decoder testbench
// Sends scancode and read words through the valid/ready input channel and
// checks every output word against its typed row or a behavioral model of
// the modifier flags, the key ring buffer and the ASCII translation. A short
// directed table comes first, then a buffer fill to overflow, then random
// typing bursts and noise under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;

  localparam int CHAR_W = skd_pkg::CHAR_W;
  localparam int CODE_W = skd_pkg::CODE_W;
  localparam int BYTE_W = skd_pkg::BYTE_W;
  localparam logic REQ_SCAN = skd_pkg::REQ_SCAN;
  localparam logic REQ_READ = skd_pkg::REQ_READ;
  localparam int RING_DEPTH = skd_pkg::FIFO_DEPTH_DEF;
  localparam int TABLE_LEN = 59;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic              key_valid;
    logic [CHAR_W-1:0] char_code;
    logic [CODE_W-1:0] key_code;
    logic              dropped;
    logic              shift_down;
    logic              ctrl_down;
    logic              alt_down;
    logic              caps_on;
  } key_result_t;

  typedef struct packed {
    logic              req;
    logic [BYTE_W-1:0] scan;
    logic              typed;
    key_result_t       res;
  } dir_row_t;

  localparam logic [CHAR_W-1:0] PLAIN_KEYS [0:TABLE_LEN-1] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  localparam logic [CHAR_W-1:0] SHIFTED_KEYS [0:TABLE_LEN-1] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  localparam logic [CODE_W-1:0] MOD_KEYS [0:4] = '{
    skd_pkg::SC_LSHIFT, skd_pkg::SC_RSHIFT, skd_pkg::SC_CTRL, skd_pkg::SC_ALT,
    skd_pkg::SC_CAPS
  };

  localparam key_result_t NO_KEY = '0;
  localparam int DIR_LEN = 25;

  localparam dir_row_t DIR_TAB [0:DIR_LEN-1] = '{
    '{REQ_READ, 8'h00, 1'b1, NO_KEY},
    '{REQ_SCAN, 8'h00, 1'b1, NO_KEY},
    '{REQ_SCAN, 8'h7F, 1'b1, NO_KEY},
    '{REQ_SCAN, 8'hFF, 1'b1, NO_KEY},
    '{REQ_READ, 8'h00, 1'b1, '{1'b1, 7'h00, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{REQ_READ, 8'hFF, 1'b1, '{1'b1, 7'h00, 7'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{REQ_SCAN, 8'h2A, 1'b1, '{1'b0, 7'h00, 7'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{REQ_SCAN, 8'h1E, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'h02, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'h3A, 1'b1, '{1'b0, 7'h00, 7'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{REQ_READ, 8'h00, 1'b0, NO_KEY},
    '{REQ_READ, 8'h00, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'hAA, 1'b1, '{1'b0, 7'h00, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{REQ_SCAN, 8'h1D, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'h38, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'h36, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'h10, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'h3B, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'h9D, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'hB8, 1'b0, NO_KEY},
    '{REQ_READ, 8'h00, 1'b0, NO_KEY},
    '{REQ_READ, 8'h00, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'hB6, 1'b0, NO_KEY},
    '{REQ_SCAN, 8'hBA, 1'b0, NO_KEY},
    '{REQ_READ, 8'h00, 1'b1, '{1'b0, 7'h00, 7'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              req_type = 1'b0;
  logic [BYTE_W-1:0] scan_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              key_valid;
  logic [CHAR_W-1:0] char_code;
  logic [CODE_W-1:0] key_code;
  logic              dropped;
  logic              shift_down;
  logic              ctrl_down;
  logic              alt_down;
  logic              caps_on;

  logic [CODE_W-1:0] key_ring [0:RING_DEPTH-1];
  int                rd_slot = 0;
  int                wr_slot = 0;
  logic              shift_st = 1'b0;
  logic              ctrl_st = 1'b0;
  logic              alt_st = 1'b0;
  logic              caps_st = 1'b0;

  key_result_t       pending_keys [$];
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                err_cnt = 0;
  int                words_sent = 0;
  int                results_seen = 0;
  int                keys_popped = 0;
  int                keys_dropped = 0;
  int                quiet_cycles = 0;

  scancode_keyboard_decoder_fifo DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .scan_byte  (scan_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .key_valid  (key_valid),
    .char_code  (char_code),
    .key_code   (key_code),
    .dropped    (dropped),
    .shift_down (shift_down),
    .ctrl_down  (ctrl_down),
    .alt_down   (alt_down),
    .caps_on    (caps_on)
  );

  always #6 clk = ~clk;

  function automatic logic is_modifier(input logic [CODE_W-1:0] code);
    return code == skd_pkg::SC_LSHIFT || code == skd_pkg::SC_RSHIFT ||
           code == skd_pkg::SC_CTRL || code == skd_pkg::SC_ALT ||
           code == skd_pkg::SC_CAPS;
  endfunction

  function automatic key_result_t decode_word(input logic req,
                                             input logic [BYTE_W-1:0] scan);
    key_result_t       r;
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] base;
    logic              upper;
    int                nxt;
    r = '0;
    code = scan[CODE_W-1:0];
    if (req == REQ_SCAN) begin
      if (scan[BYTE_W-1]) begin
        if (code == skd_pkg::SC_LSHIFT || code == skd_pkg::SC_RSHIFT) shift_st = 1'b0;
        else if (code == skd_pkg::SC_CTRL) ctrl_st = 1'b0;
        else if (code == skd_pkg::SC_ALT) alt_st = 1'b0;
      end else if (code == skd_pkg::SC_LSHIFT || code == skd_pkg::SC_RSHIFT) begin
        shift_st = 1'b1;
      end else if (code == skd_pkg::SC_CTRL) begin
        ctrl_st = 1'b1;
      end else if (code == skd_pkg::SC_ALT) begin
        alt_st = 1'b1;
      end else if (code == skd_pkg::SC_CAPS) begin
        caps_st = ~caps_st;
      end else begin
        nxt = (wr_slot + 1) % RING_DEPTH;
        if (nxt == rd_slot) begin
          r.dropped = 1'b1;
        end else begin
          key_ring[wr_slot] = code;
          wr_slot = nxt;
        end
      end
    end else if (rd_slot != wr_slot) begin
      code = key_ring[rd_slot];
      rd_slot = (rd_slot + 1) % RING_DEPTH;
      r.key_valid = 1'b1;
      r.key_code = code;
      if (code < TABLE_LEN) begin
        base = PLAIN_KEYS[code];
        upper = (base >= 7'h61 && base <= 7'h7A) ? (shift_st ^ caps_st) : shift_st;
        r.char_code = upper ? SHIFTED_KEYS[code] : base;
      end
    end
    r.shift_down = shift_st;
    r.ctrl_down = ctrl_st;
    r.alt_down = alt_st;
    r.caps_on = caps_st;
    return r;
  endfunction

  task automatic send_word(input logic req, input logic [BYTE_W-1:0] scan,
                           input logic typed = 1'b0,
                           input key_result_t typed_res = '0);
    key_result_t pred;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    scan_byte <= scan;
    do @(posedge clk); while (!in_ready);
    pred = decode_word(req, scan);
    pending_keys.push_back(typed ? typed_res : pred);
    words_sent++;
  endtask

  function automatic logic [CODE_W-1:0] pick_key();
    logic [CODE_W-1:0] c;
    do begin
      if ($urandom_range(9) == 0) c = CODE_W'($urandom_range(TABLE_LEN, 127));
      else c = CODE_W'($urandom_range(0, TABLE_LEN - 1));
    end while (is_modifier(c));
    return c;
  endfunction

  task automatic typing_burst();
    int n;
    int k;
    int reads;
    n = $urandom_range(1, 12);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        6: send_word(REQ_SCAN, {1'b0, MOD_KEYS[$urandom_range(4)]});
        7: send_word(REQ_SCAN, {1'b1, MOD_KEYS[$urandom_range(4)]});
        8: send_word(REQ_READ, BYTE_W'($urandom_range(255)));
        9: send_word(REQ_SCAN, {1'b1, CODE_W'($urandom_range(127))});
        default: send_word(REQ_SCAN, {1'b0, pick_key()});
      endcase
    end
    reads = $urandom_range(n + 1, (n > 3) ? n - 3 : 0);
    for (k = 0; k < reads; k++) send_word(REQ_READ, BYTE_W'($urandom_range(255)));
  endtask

  task automatic noise_burst();
    int k;
    for (k = $urandom_range(1, 6); k > 0; k--)
      send_word(1'($urandom_range(1)), BYTE_W'($urandom_range(255)));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int goal);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (words_sent < goal) begin
      if ($urandom_range(9) < 7) typing_burst();
      else noise_burst();
    end
  endtask

  task automatic check_field(input string name, input logic [6:0] exp_v,
                             input logic [6:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    key_result_t exp_r;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", pending_keys.size());
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_keys.size() == 0) begin
          $error("output word with no expectation outstanding");
          err_cnt++;
        end else begin
          exp_r = pending_keys.pop_front();
          if (exp_r.key_valid) keys_popped++;
          if (exp_r.dropped) keys_dropped++;
          check_field("key_valid", 7'(exp_r.key_valid), 7'(key_valid));
          check_field("char_code", exp_r.char_code, char_code);
          check_field("key_code", exp_r.key_code, key_code);
          check_field("dropped", 7'(exp_r.dropped), 7'(dropped));
          check_field("shift_down", 7'(exp_r.shift_down), 7'(shift_down));
          check_field("ctrl_down", 7'(exp_r.ctrl_down), 7'(ctrl_down));
          check_field("alt_down", 7'(exp_r.alt_down), 7'(alt_down));
          check_field("caps_on", 7'(exp_r.caps_on), 7'(caps_on));
        end
      end
    end
  end

  initial begin
    int k;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (k = 0; k < DIR_LEN; k++)
      send_word(DIR_TAB[k].req, DIR_TAB[k].scan, DIR_TAB[k].typed, DIR_TAB[k].res);
    for (k = 0; k < RING_DEPTH + 2; k++) send_word(REQ_SCAN, {1'b0, pick_key()});
    for (k = 0; k < RING_DEPTH; k++) send_word(REQ_READ, BYTE_W'($urandom_range(255)));
    run_phase(0, 0, 700);
    run_phase(87, 0, 950);
    run_phase(0, 87, 1200);
    run_phase(19, 19, 1400);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_keys.size() != 0) begin
      $error("%0d expected results never arrived", pending_keys.size());
      err_cnt++;
    end
    $display("Sent %0d words, checked %0d results: %0d keys read back, %0d overflow drops.",
             words_sent, results_seen, keys_popped, keys_dropped);
    $display("Covered directed cases, a buffer overflow and four idle/stall mixes.");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
